// ===== rtl/core/sab_pkg.sv =====
package sab_pkg;

  localparam int MAX_STATES_DEF = 1024;
  localparam int ALPHABET_DEF   = 26;

  localparam logic        ACT_EXTEND  = 1'b0;
  localparam logic        ACT_READ    = 1'b1;
  localparam logic        STATUS_DONE = 1'b0;
  localparam logic        STATUS_FULL = 1'b1;
  localparam logic [10:0] NODE_NONE   = 11'h7FF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_E0,
    ST_E1,
    ST_E2,
    ST_ZERO,
    ST_W0,
    ST_W1,
    ST_W2,
    ST_COPY,
    ST_C3,
    ST_CW0,
    ST_CW1,
    ST_ER,
    ST_EO
  } sab_state_t;

endpackage

// ===== rtl/core/sab_ram.sv =====
module sab_ram import sab_pkg::*; #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/suffix_automaton_builder.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready  | action, node, symbol
// out     | output    | out_valid/out_ready| status, result_node, node_length,
//         |           |                    | suffix_link, next_state, node_count
// A read passes through the read and emit steps. An extend clears the row of a
// new state column by column, walks the suffix links one step at a time and
// copies each clone row column by column, set by the one read and one write
// port of the transition memory. After reset the root row is cleared and no
// item is accepted until then. The result register lets a result wait while
// the block returns to idle; a stalled output holds only the final emit step.
module suffix_automaton_builder import sab_pkg::*; #(
  parameter int MAX_STATES = MAX_STATES_DEF,
  parameter int ALPHABET   = ALPHABET_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               action,
  input  logic signed [10:0] node,
  input  logic [4:0]         symbol,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               status,
  output logic [9:0]         result_node,
  output logic [9:0]         node_length,
  output logic signed [10:0] suffix_link,
  output logic [9:0]         next_state,
  output logic [10:0]        node_count
);

  localparam int NW   = $clog2(MAX_STATES);
  localparam int SW   = $clog2(MAX_STATES + 1);
  localparam int CW   = $clog2(ALPHABET);
  localparam int CNTW = $clog2(ALPHABET + 1);
  localparam int TXD  = MAX_STATES * ALPHABET;
  localparam int TXAW = $clog2(TXD);
  localparam int LLW  = 2 * NW + 1;

  sab_state_t state, state_next;

  // datapath registers
  logic signed [NW:0] p;
  logic [CW-1:0]      x_col;
  logic [NW-1:0]      q, n, r, lenp, lenq, lenn, rd_idx;
  logic [9:0]         rn;
  logic [SW-1:0]      su, guard;
  logic [CNTW-1:0]    cnt;
  logic               clone_link, rd_ok, sym_ok, full;

  // memory ports
  logic            tx_we, tx_re, ll_we, ll_re;
  logic [NW-1:0]   tx_wrow, tx_rrow, ll_waddr, ll_raddr;
  logic [CW-1:0]   tx_wcol, tx_rcol;
  logic [NW-1:0]   tx_wdata, tx_rd;
  logic [TXAW-1:0] tx_waddr, tx_raddr;
  logic [LLW-1:0]  ll_wdata, ll_rd;
  logic            out_load;

  logic [NW-1:0]      ll_len;
  logic signed [NW:0] ll_link;
  logic p_use, guard_ok, tx_zero, len_hit, cnt_last, copy_done;
  logic in_use_in, sym_in, full_in, none_in;

  assign ll_len  = ll_rd[LLW-1 -: NW];
  assign ll_link = ll_rd[NW:0];

  assign tx_waddr = TXAW'(32'(tx_wrow) * ALPHABET + 32'(tx_wcol));
  assign tx_raddr = TXAW'(32'(tx_rrow) * ALPHABET + 32'(tx_rcol));

  assign p_use     = !p[NW] && (SW'(p[NW-1:0]) < su);
  assign guard_ok  = guard < SW'(MAX_STATES);
  assign tx_zero   = (tx_rd == '0);
  assign len_hit   = (ll_len == NW'(lenp + 1'b1));
  assign cnt_last  = (cnt == CNTW'(ALPHABET - 1));
  assign copy_done = (cnt == CNTW'(ALPHABET));

  assign none_in   = (node == NODE_NONE);
  assign in_use_in = !node[10] && (32'(node[9:0]) < 32'(su));
  assign sym_in    = (32'(symbol) < ALPHABET);
  assign full_in   = (32'(su) + 2 > MAX_STATES);

  sab_ram #(.WIDTH(NW), .DEPTH(TXD)) u_tx_ram (
    .clk   (clk),
    .we    (tx_we),
    .waddr (tx_waddr),
    .wdata (tx_wdata),
    .re    (tx_re),
    .raddr (tx_raddr),
    .rdata (tx_rd)
  );

  sab_ram #(.WIDTH(LLW), .DEPTH(MAX_STATES)) u_ll_ram (
    .clk   (clk),
    .we    (ll_we),
    .waddr (ll_waddr),
    .wdata (ll_wdata),
    .re    (ll_re),
    .raddr (ll_raddr),
    .rdata (ll_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (cnt_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_valid) begin
          if (action == ACT_EXTEND && !none_in && in_use_in && sym_in) begin
            state_next = full_in ? ST_EO : ST_E0;
          end else begin
            state_next = ST_ER;
          end
        end
      end
      ST_E0:   state_next = ST_E1;
      ST_E1:   state_next = tx_zero ? ST_ZERO : ST_E2;
      ST_E2:   state_next = len_hit ? ST_ER : ST_COPY;
      ST_ZERO: if (cnt_last) state_next = ST_W0;
      ST_W0:   state_next = p_use ? ST_W1 : ST_ER;
      ST_W1:   state_next = (tx_zero && guard_ok) ? ST_W0 : ST_W2;
      ST_W2:   state_next = len_hit ? ST_ER : ST_COPY;
      ST_COPY: if (copy_done) state_next = ST_C3;
      ST_C3:   state_next = ST_CW0;
      ST_CW0:  state_next = (p_use && guard_ok) ? ST_CW1 : ST_ER;
      ST_CW1:  state_next = (tx_rd == q) ? ST_CW0 : ST_ER;
      ST_ER:   state_next = ST_EO;
      ST_EO:   if (!out_valid || out_ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    in_ready = 1'b0;
    out_load = 1'b0;
    tx_we    = 1'b0;
    tx_wrow  = n;
    tx_wcol  = CW'(cnt);
    tx_wdata = '0;
    tx_re    = 1'b0;
    tx_rrow  = p[NW-1:0];
    tx_rcol  = x_col;
    ll_we    = 1'b0;
    ll_waddr = n;
    ll_wdata = {lenn, {(NW + 1){1'b0}}};
    ll_re    = 1'b0;
    ll_raddr = p[NW-1:0];
    unique case (state)
      ST_CLEAR: begin
        tx_we   = 1'b1;
        tx_wrow = '0;
        if (cnt == '0) begin
          ll_we    = 1'b1;
          ll_waddr = '0;
          ll_wdata = {NW'(0), {(NW + 1){1'b1}}};
        end
      end
      ST_IDLE: in_ready = 1'b1;
      ST_E0, ST_W0, ST_CW0: begin
        tx_re = (state == ST_E0) || (p_use && (state == ST_W0 || guard_ok));
        ll_re = tx_re;
        if (state == ST_W0 && !p_use) begin
          ll_we = 1'b1;
        end
        if (state == ST_CW0 && !(p_use && guard_ok) && clone_link) begin
          ll_we    = 1'b1;
          ll_wdata = {lenn, (NW + 1)'($signed({1'b0, r}))};
        end
      end
      ST_E1: begin
        if (tx_zero) begin
          ll_we    = 1'b1;
          ll_waddr = NW'(su);
          ll_wdata = {NW'(ll_len + 1'b1), {(NW + 1){1'b0}}};
        end else begin
          ll_re    = 1'b1;
          ll_raddr = tx_rd;
        end
      end
      ST_E2, ST_W2: begin
        if (len_hit) begin
          if (state == ST_W2) begin
            ll_we    = 1'b1;
            ll_wdata = {lenn, (NW + 1)'($signed({1'b0, q}))};
          end
        end else begin
          ll_we    = 1'b1;
          ll_waddr = NW'(su);
          ll_wdata = {NW'(lenp + 1'b1), ll_link};
        end
      end
      ST_ZERO: tx_we = 1'b1;
      ST_W1: begin
        if (tx_zero && guard_ok) begin
          tx_we    = 1'b1;
          tx_wrow  = p[NW-1:0];
          tx_wcol  = x_col;
          tx_wdata = n;
        end else begin
          ll_re    = 1'b1;
          ll_raddr = tx_rd;
        end
      end
      ST_COPY: begin
        // read column cnt of q, write column cnt-1 of the clone
        tx_re   = !copy_done;
        tx_rrow = q;
        tx_rcol = CW'(cnt);
        if (cnt != '0) begin
          tx_we    = 1'b1;
          tx_wrow  = r;
          tx_wcol  = CW'(cnt - 1'b1);
          tx_wdata = tx_rd;
        end
      end
      ST_C3: begin
        ll_we    = 1'b1;
        ll_waddr = q;
        ll_wdata = {lenq, (NW + 1)'($signed({1'b0, r}))};
      end
      ST_CW1: begin
        if (tx_rd == q) begin
          tx_we    = 1'b1;
          tx_wrow  = p[NW-1:0];
          tx_wcol  = x_col;
          tx_wdata = r;
        end else if (clone_link) begin
          ll_we    = 1'b1;
          ll_wdata = {lenn, (NW + 1)'($signed({1'b0, r}))};
        end
      end
      ST_ER: begin
        tx_re    = rd_ok;
        tx_rrow  = rd_idx;
        ll_re    = rd_ok;
        ll_raddr = rd_idx;
      end
      ST_EO: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      su    <= SW'(1);
      cnt   <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_CLEAR: cnt <= cnt_last ? '0 : cnt + 1'b1;
        ST_IDLE: begin
          x_col  <= CW'(symbol);
          sym_ok <= sym_in;
          full   <= 1'b0;
          rn     <= node[9:0];
          rd_idx <= NW'(node[9:0]);
          rd_ok  <= in_use_in;
          if (action == ACT_EXTEND && none_in) begin
            rn     <= '0;
            rd_idx <= '0;
            rd_ok  <= 1'b1;
          end else if (action == ACT_EXTEND && in_use_in && sym_in) begin
            p     <= (NW + 1)'($signed({1'b0, node[9:0]}));
            full  <= full_in;
            rn    <= '0;
            rd_ok <= 1'b0;
          end
        end
        ST_E1: begin
          q     <= tx_rd;
          lenp  <= ll_len;
          guard <= '0;
          cnt   <= '0;
          if (tx_zero) begin
            n    <= NW'(su);
            lenn <= NW'(ll_len + 1'b1);
            su   <= su + 1'b1;
          end
        end
        ST_E2, ST_W2: begin
          lenq <= ll_len;
          cnt  <= '0;
          if (len_hit) begin
            rn     <= 10'((state == ST_E2) ? q : n);
            rd_idx <= (state == ST_E2) ? q : n;
            rd_ok  <= 1'b1;
          end else begin
            clone_link <= (state == ST_W2);
            r          <= NW'(su);
            su         <= su + 1'b1;
          end
        end
        ST_ZERO: cnt <= cnt_last ? '0 : cnt + 1'b1;
        ST_W0: begin
          if (!p_use) begin
            rn     <= 10'(n);
            rd_idx <= n;
            rd_ok  <= 1'b1;
          end
        end
        ST_W1: begin
          if (tx_zero && guard_ok) begin
            p     <= ll_link;
            guard <= guard + 1'b1;
          end else begin
            q    <= tx_rd;
            lenp <= ll_len;
          end
        end
        ST_COPY: cnt <= copy_done ? '0 : cnt + 1'b1;
        ST_C3:   guard <= '0;
        ST_CW0: begin
          if (!(p_use && guard_ok)) begin
            rn     <= 10'(clone_link ? n : r);
            rd_idx <= clone_link ? n : r;
            rd_ok  <= 1'b1;
          end
        end
        ST_CW1: begin
          if (tx_rd == q) begin
            p     <= ll_link;
            guard <= guard + 1'b1;
          end else begin
            rn     <= 10'(clone_link ? n : r);
            rd_idx <= clone_link ? n : r;
            rd_ok  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      status      <= full ? STATUS_FULL : STATUS_DONE;
      result_node <= rn;
      node_length <= rd_ok ? 10'(ll_len) : '0;
      suffix_link <= rd_ok ? 11'(ll_link) : '0;
      next_state  <= (rd_ok && sym_ok) ? 10'(tx_rd) : '0;
      node_count  <= 11'(su);
    end
  end

`ifndef SYNTH
  a_su_grows: assert property (@(posedge clk) disable iff (rst) su >= $past(su))
    else $error("state count decreased");
  a_su_cap: assert property (@(posedge clk) disable iff (rst) 32'(su) <= MAX_STATES)
    else $error("state count above capacity");
  a_walk_edge: assert property (@(posedge clk) disable iff (rst)
    tx_we && (state == ST_W1 || state == ST_CW1) |-> tx_wdata != '0)
    else $error("walk wrote an empty edge");
  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |->
      result_node == '0 && node_length == '0 && next_state == '0)
    else $error("refused extend returned node fields");
`endif

endmodule
